### hdl/iqas_pkg.sv
package iqas_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAG_BITS    = SAMPLE_BITS + 1;   // -32768 gives 32768
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int COUNT_BITS  = 64;
    localparam int BIN_COUNT   = 8;
    localparam int BIN_BITS    = $clog2(BIN_COUNT);
    localparam int LEVEL_BITS  = 16;
    localparam int INDEX_BITS  = 5;
    localparam int CMD_BITS    = 2;
    localparam int CFG_BITS    = 1;

    // level registers after reset
    localparam logic [LEVEL_BITS-1:0] NEAR_LEVEL_RST = 16'd30000;
    localparam logic [LEVEL_BITS-1:0] SAT_LEVEL_RST  = 16'd32767;

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_NEAR_LEVEL = 1'b0;
    localparam logic [CFG_BITS-1:0] CFG_SAT_LEVEL  = 1'b1;

    // read select codes beyond the two histograms
    localparam logic [INDEX_BITS-1:0] STAT_TOTAL  = 5'd16;
    localparam logic [INDEX_BITS-1:0] STAT_SAT    = 5'd17;
    localparam logic [INDEX_BITS-1:0] STAT_NEAR   = 5'd18;
    localparam logic [INDEX_BITS-1:0] STAT_SUMSQ_I = 5'd19;
    localparam logic [INDEX_BITS-1:0] STAT_SUMSQ_Q = 5'd20;
    localparam logic [INDEX_BITS-1:0] STAT_PEAK_I = 5'd21;
    localparam logic [INDEX_BITS-1:0] STAT_PEAK_Q = 5'd22;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_RECORD = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef logic [BIN_COUNT-1:0][COUNT_BITS-1:0] t_bin_counts;

    // merge stage to lanes
    typedef struct packed {
        logic en;    // pipeline advances
        logic rec;   // record word leaves stage 1
        logic clr;   // clear word leaves stage 1
    } t_lane_ctrl;

    // lane stage 1 findings used by the merge stage
    typedef struct packed {
        logic ge_sat;
        logic ge_near;
    } t_lane_flags;

endpackage

### hdl/iqas_lane.sv
module iqas_lane
    import iqas_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic [LEVEL_BITS-1:0]         i_near_level,
    input  logic [LEVEL_BITS-1:0]         i_sat_level,
    output t_lane_flags                   o_flags,
    output t_bin_counts                   o_bins,
    output logic [COUNT_BITS-1:0]         o_sumsq,
    output logic [MAG_BITS-1:0]           o_peak
);

    localparam logic [MAG_BITS-1:0] EDGE_1 = 17'd1024;
    localparam logic [MAG_BITS-1:0] EDGE_2 = 17'd4096;
    localparam logic [MAG_BITS-1:0] EDGE_3 = 17'd8192;
    localparam logic [MAG_BITS-1:0] EDGE_4 = 17'd16384;
    localparam logic [MAG_BITS-1:0] EDGE_5 = 17'd24576;
    localparam logic [MAG_BITS-1:0] EDGE_6 = 17'd32767;

    logic signed [MAG_BITS-1:0] sx;
    logic [MAG_BITS-1:0]        mag;
    logic [BIN_BITS-1:0]        bin;
    logic signed [SQ_BITS-1:0]  sq_full;

    // stage 1
    logic [MAG_BITS-1:0] r_mag;
    logic [BIN_BITS-1:0] r_bin;
    logic [SQ_BITS-1:0]  r_sq;
    t_lane_flags         r_flags;

    // statistics
    t_bin_counts           r_bins;
    logic [COUNT_BITS-1:0] r_sumsq;
    logic [MAG_BITS-1:0]   r_peak;

    // magnitude, bin and square of the sample
    assign sx      = {i_sample[SAMPLE_BITS-1], i_sample};
    assign mag     = i_sample[SAMPLE_BITS-1] ? MAG_BITS'(-sx) : MAG_BITS'(sx);
    assign sq_full = i_sample * i_sample;

    always_comb begin
        if (mag == '0)         bin = BIN_BITS'(0);
        else if (mag < EDGE_1) bin = BIN_BITS'(1);
        else if (mag < EDGE_2) bin = BIN_BITS'(2);
        else if (mag < EDGE_3) bin = BIN_BITS'(3);
        else if (mag < EDGE_4) bin = BIN_BITS'(4);
        else if (mag < EDGE_5) bin = BIN_BITS'(5);
        else if (mag < EDGE_6) bin = BIN_BITS'(6);
        else                   bin = BIN_BITS'(7);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_mag           <= mag;
            r_bin           <= bin;
            r_sq            <= $unsigned(sq_full);
            r_flags.ge_sat  <= mag >= MAG_BITS'(i_sat_level);
            r_flags.ge_near <= mag >= MAG_BITS'(i_near_level);
        end
    end

    // accumulate into bins, sum of squares and peak
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clr) begin
            r_bins  <= '0;
            r_sumsq <= '0;
            r_peak  <= '0;
        end else if (i_ctrl.rec) begin
            for (int k = 0; k < BIN_COUNT; k++) begin
                if (r_bin == BIN_BITS'(k)) r_bins[k] <= r_bins[k] + 1'b1;
            end
            r_sumsq <= r_sumsq + COUNT_BITS'(r_sq);
            if (r_mag > r_peak) r_peak <= r_mag;
        end
    end

    assign o_flags = r_flags;
    assign o_bins  = r_bins;
    assign o_sumsq = r_sumsq;
    assign o_peak  = r_peak;

endmodule

### hdl/iqas_merge.sv
module iqas_merge
    import iqas_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [CMD_BITS-1:0]    i_command,
    input  logic [INDEX_BITS-1:0]  i_stat_index,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [COUNT_BITS-1:0]  o_stat_value,
    output t_lane_ctrl             o_ctrl,
    input  t_lane_flags            i_flags_i,
    input  t_lane_flags            i_flags_q,
    input  t_bin_counts            i_bins_i,
    input  t_bin_counts            i_bins_q,
    input  logic [COUNT_BITS-1:0]  i_sumsq_i,
    input  logic [COUNT_BITS-1:0]  i_sumsq_q,
    input  logic [MAG_BITS-1:0]    i_peak_i,
    input  logic [MAG_BITS-1:0]    i_peak_q
);

    logic                  r_s1_valid;
    t_cmd                  r_s1_cmd;
    logic [INDEX_BITS-1:0] r_s1_idx;

    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_sat;
    logic [COUNT_BITS-1:0] r_near;

    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_value;

    logic                  s1_read;
    logic                  en;
    logic [COUNT_BITS-1:0] rd_value;
    t_lane_ctrl            ctrl;

    // only a read waiting on a full output word holds the pipeline
    assign s1_read = r_s1_valid && (r_s1_cmd == CMD_READ);
    assign en      = !(s1_read && r_out_valid && !i_out_ready);

    always_comb begin
        ctrl.en  = en;
        ctrl.rec = en && r_s1_valid && (r_s1_cmd == CMD_RECORD);
        ctrl.clr = en && r_s1_valid && (r_s1_cmd == CMD_CLEAR);
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_cmd <= t_cmd'(i_command);
            r_s1_idx <= i_stat_index;
        end
    end

    // counters that combine both lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || ctrl.clr) begin
            r_total <= '0;
            r_sat   <= '0;
            r_near  <= '0;
        end else if (ctrl.rec) begin
            r_total <= r_total + 1'b1;
            if (i_flags_i.ge_sat || i_flags_q.ge_sat)   r_sat  <= r_sat + 1'b1;
            if (i_flags_i.ge_near || i_flags_q.ge_near) r_near <= r_near + 1'b1;
        end
    end

    // read select
    always_comb begin
        if (!r_s1_idx[INDEX_BITS-1]) begin
            if (r_s1_idx[BIN_BITS]) rd_value = i_bins_q[r_s1_idx[BIN_BITS-1:0]];
            else                    rd_value = i_bins_i[r_s1_idx[BIN_BITS-1:0]];
        end else begin
            unique case (r_s1_idx)
                STAT_TOTAL:   rd_value = r_total;
                STAT_SAT:     rd_value = r_sat;
                STAT_NEAR:    rd_value = r_near;
                STAT_SUMSQ_I: rd_value = i_sumsq_i;
                STAT_SUMSQ_Q: rd_value = i_sumsq_q;
                STAT_PEAK_I:  rd_value = COUNT_BITS'(i_peak_i);
                STAT_PEAK_Q:  rd_value = COUNT_BITS'(i_peak_q);
                default:      rd_value = '0;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en && s1_read) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && s1_read) r_out_value <= rd_value;
    end

    assign o_in_ready   = en;
    assign o_out_valid  = r_out_valid;
    assign o_stat_value = r_out_value;
    assign o_ctrl       = ctrl;

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |-> (s1_read && r_out_valid))
        else $error("pipeline held without a pending read");

    a_total_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.rec |=> r_total == $past(r_total) + 1'b1)
        else $error("total count missed a record");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clr |=> (r_total == '0 && r_sat == '0 && r_near == '0))
        else $error("clear left a counter set");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_read && en))
        else $error("output word without a read");

endmodule

### hdl/iq_amplitude_statistics_top.sv
// I/Q amplitude statistics.
// Input channel (i_in_valid / o_in_ready) carries one word per handshake:
// a command (record, read, clear), an I and a Q sample and a read select.
// Record bins |I| and |Q| into two eight-bin histograms and updates total,
// saturated and near-saturated counts, sums of squares and peaks. Clear
// zeroes all statistics. Read returns one 64-bit statistic on the output
// channel (o_out_valid / i_out_ready); record and clear return nothing.
// Throughput is one word per cycle; each lane has a 16x16 multiplier
// registered ahead of the 64-bit accumulators, which sets the two stages.
// A read result passes through stage 1 and then the output word register, and
// it reflects every word accepted before it.
// When the receiver stalls, the pipeline keeps accepting records and clears;
// it holds only when a read reaches stage 1 while the output word is full.
// Reset (synchronous, active low) zeroes all statistics and loads the level
// registers with 30000 (near) and 32767 (saturated). The user must write
// levels through the cfg port while idle; the block does not enforce this.
module iq_amplitude_statistics_top
    import iqas_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [CMD_BITS-1:0]           i_command,
    input  logic signed [SAMPLE_BITS-1:0] i_i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_q_sample,
    input  logic [INDEX_BITS-1:0]         i_stat_index,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [COUNT_BITS-1:0]         o_stat_value,
    input  logic                          i_cfg_we,
    input  logic [CFG_BITS-1:0]           i_cfg_index,
    input  logic [LEVEL_BITS-1:0]         i_cfg_data
);

    logic [LEVEL_BITS-1:0] r_near_level;
    logic [LEVEL_BITS-1:0] r_sat_level;

    t_lane_ctrl            ctrl;
    t_lane_flags           flags_i, flags_q;
    t_bin_counts           bins_i, bins_q;
    logic [COUNT_BITS-1:0] sumsq_i, sumsq_q;
    logic [MAG_BITS-1:0]   peak_i, peak_q;

    // level registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_level <= NEAR_LEVEL_RST;
            r_sat_level  <= SAT_LEVEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEAR_LEVEL: r_near_level <= i_cfg_data;
                CFG_SAT_LEVEL:  r_sat_level  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    iqas_lane u_lane_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_sample     (i_i_sample),
        .i_near_level (r_near_level),
        .i_sat_level  (r_sat_level),
        .o_flags      (flags_i),
        .o_bins       (bins_i),
        .o_sumsq      (sumsq_i),
        .o_peak       (peak_i)
    );

    iqas_lane u_lane_q (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_sample     (i_q_sample),
        .i_near_level (r_near_level),
        .i_sat_level  (r_sat_level),
        .o_flags      (flags_q),
        .o_bins       (bins_q),
        .o_sumsq      (sumsq_q),
        .o_peak       (peak_q)
    );

    iqas_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_stat_index (i_stat_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_stat_value (o_stat_value),
        .o_ctrl       (ctrl),
        .i_flags_i    (flags_i),
        .i_flags_q    (flags_q),
        .i_bins_i     (bins_i),
        .i_bins_q     (bins_q),
        .i_sumsq_i    (sumsq_i),
        .i_sumsq_q    (sumsq_q),
        .i_peak_i     (peak_i),
        .i_peak_q     (peak_q)
    );

endmodule

### tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iqas_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 104;
    localparam int LONG_HOLD        = 300;
    localparam int TAIL_CYCLES      = 10;
    localparam int CYCLE_LIMIT      = 300000;

    typedef struct packed {
        logic [CMD_BITS-1:0]    cmd;
        logic [SAMPLE_BITS-1:0] i_s;
        logic [SAMPLE_BITS-1:0] q_s;
        logic [INDEX_BITS-1:0]  idx;
    } t_word;

    // DUT ports
    logic                          i_clk;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [CMD_BITS-1:0]           i_command    = '0;
    logic signed [SAMPLE_BITS-1:0] i_i_sample   = '0;
    logic signed [SAMPLE_BITS-1:0] i_q_sample   = '0;
    logic [INDEX_BITS-1:0]         i_stat_index = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [COUNT_BITS-1:0]         o_stat_value;
    logic                          i_cfg_we     = 1'b0;
    logic [CFG_BITS-1:0]           i_cfg_index  = '0;
    logic [LEVEL_BITS-1:0]         i_cfg_data   = '0;

    iq_amplitude_statistics_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_i_sample   (i_i_sample),
        .i_q_sample   (i_q_sample),
        .i_stat_index (i_stat_index),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_stat_value (o_stat_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // statistics as the block should hold them
    logic [COUNT_BITS-1:0] hist_i [BIN_COUNT];
    logic [COUNT_BITS-1:0] hist_q [BIN_COUNT];
    logic [COUNT_BITS-1:0] total_cnt, sat_cnt, near_cnt, sumsq_i, sumsq_q;
    logic [MAG_BITS-1:0]   peak_i, peak_q;
    logic [LEVEL_BITS-1:0] near_level, sat_level;

    t_word                 word_queue[$];
    logic [COUNT_BITS-1:0] stat_values_due[$];
    int                    failures = 0;

    // |x| of a two's complement sample, -32768 gives 32768
    function automatic logic [MAG_BITS-1:0] rail_magnitude(logic [SAMPLE_BITS-1:0] s);
        if (s[SAMPLE_BITS-1])
            return MAG_BITS'(1 << SAMPLE_BITS) - {1'b0, s};
        return {1'b0, s};
    endfunction

    function automatic int bin_for(logic [MAG_BITS-1:0] m);
        if (m == 0)     return 0;
        if (m < 1024)   return 1;
        if (m < 4096)   return 2;
        if (m < 8192)   return 3;
        if (m < 16384)  return 4;
        if (m < 24576)  return 5;
        if (m < 32767)  return 6;
        return 7;
    endfunction

    task automatic wipe_stats();
        for (int b = 0; b < BIN_COUNT; b++) begin
            hist_i[b] = '0;
            hist_q[b] = '0;
        end
        total_cnt = '0;
        sat_cnt   = '0;
        near_cnt  = '0;
        sumsq_i   = '0;
        sumsq_q   = '0;
        peak_i    = '0;
        peak_q    = '0;
    endtask

    task automatic tally_sample(logic [SAMPLE_BITS-1:0] si, logic [SAMPLE_BITS-1:0] sq);
        logic [MAG_BITS-1:0] mi, mq;
        mi = rail_magnitude(si);
        mq = rail_magnitude(sq);
        hist_i[bin_for(mi)] += 1;
        hist_q[bin_for(mq)] += 1;
        total_cnt += 1;
        if (mi >= MAG_BITS'(sat_level) || mq >= MAG_BITS'(sat_level))
            sat_cnt += 1;
        if (mi >= MAG_BITS'(near_level) || mq >= MAG_BITS'(near_level))
            near_cnt += 1;
        sumsq_i += COUNT_BITS'(mi) * COUNT_BITS'(mi);
        sumsq_q += COUNT_BITS'(mq) * COUNT_BITS'(mq);
        if (mi > peak_i) peak_i = mi;
        if (mq > peak_q) peak_q = mq;
    endtask

    function automatic logic [COUNT_BITS-1:0] read_stat(logic [INDEX_BITS-1:0] idx);
        if (idx < BIN_COUNT)     return hist_i[idx[BIN_BITS-1:0]];
        if (idx < 2 * BIN_COUNT) return hist_q[idx[BIN_BITS-1:0]];
        case (idx)
            STAT_TOTAL:   return total_cnt;
            STAT_SAT:     return sat_cnt;
            STAT_NEAR:    return near_cnt;
            STAT_SUMSQ_I: return sumsq_i;
            STAT_SUMSQ_Q: return sumsq_q;
            STAT_PEAK_I:  return COUNT_BITS'(peak_i);
            STAT_PEAK_Q:  return COUNT_BITS'(peak_q);
            default:      return '0;
        endcase
    endfunction

    task automatic apply_word(t_word w);
        case (w.cmd)
            CMD_RECORD: tally_sample(w.i_s, w.q_s);
            CMD_READ:   stat_values_due.push_back(read_stat(w.idx));
            CMD_CLEAR:  wipe_stats();
            default: ;  // unused code, ignored
        endcase
    endtask

    function automatic t_word make_word(logic [CMD_BITS-1:0] cmd, int si, int sq,
                                        int idx);
        t_word w;
        w.cmd = cmd;
        w.i_s = SAMPLE_BITS'(si);
        w.q_s = SAMPLE_BITS'(sq);
        w.idx = INDEX_BITS'(idx);
        return w;
    endfunction

    // samples biased toward bin edges, the level registers and the extremes
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int target;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3, 4: return SAMPLE_BITS'($urandom);
            5: begin
                case ($urandom_range(0, 5))
                    0:       target = 1024;
                    1:       target = 4096;
                    2:       target = 8192;
                    3:       target = 16384;
                    4:       target = 24576;
                    default: target = 32767;
                endcase
                target = target + int'($urandom_range(0, 2)) - 1;
            end
            6: target = int'(near_level) + int'($urandom_range(0, 2)) - 1;
            7: target = int'(sat_level) + int'($urandom_range(0, 2)) - 1;
            8: target = $urandom_range(0, 1) ? 32768 : 0;
            default: target = $urandom_range(0, 1023);
        endcase
        if (target < 0) target = 0;
        if (target > 32768) target = 32768;
        if (target == 32768 || $urandom_range(0, 1) == 1)
            target = -target;
        return SAMPLE_BITS'(target);
    endfunction

    function automatic t_word random_word();
        t_word w;
        int unsigned pick;
        pick  = $urandom_range(0, 99);
        w.i_s = pick_sample();
        w.q_s = pick_sample();
        if ($urandom_range(0, 7) == 0)
            w.idx = INDEX_BITS'($urandom_range(23, 31));
        else
            w.idx = INDEX_BITS'($urandom_range(0, 22));
        if (pick < 60)      w.cmd = CMD_RECORD;
        else if (pick < 93) w.cmd = CMD_READ;
        else if (pick < 96) w.cmd = CMD_CLEAR;
        else                w.cmd = CMD_UNUSED;
        return w;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // input driver: one word at a time from word_queue, random gap after each
    int unsigned gap_left = 0;
    bit          tx_calm  = 1'b0;
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (gap_left != 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (word_queue.size() != 0) begin
                w = word_queue.pop_front();
                i_in_valid   <= 1'b1;
                i_command    <= w.cmd;
                i_i_sample   <= w.i_s;
                i_q_sample   <= w.q_s;
                i_stat_index <= w.idx;
                if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
                gap_left <= tx_calm ? 0 : $urandom_range(0, 19);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output receiver: random stall after each word, two long hold-offs
    int unsigned rx_wait  = 0;
    int unsigned rx_taken = 0;
    bit          rx_calm  = 1'b0;
    always @(posedge i_clk) begin
        int unsigned hold;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_wait     <= 0;
        end else if (o_out_valid && i_out_ready) begin
            rx_taken <= rx_taken + 1;
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            if (rx_taken == 40 || rx_taken == 170)
                hold = LONG_HOLD;
            else
                hold = rx_calm ? 0 : $urandom_range(0, 19);
            rx_wait     <= hold;
            i_out_ready <= (hold == 0);
        end else if (rx_wait != 0) begin
            rx_wait     <= rx_wait - 1;
            i_out_ready <= (rx_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: check results first, then fold in the word accepted at this edge
    always @(posedge i_clk) begin
        t_word                 w;
        logic [COUNT_BITS-1:0] want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (stat_values_due.size() == 0) begin
                    $error("stat_value: expected none, actual %0h", o_stat_value);
                    failures++;
                end else begin
                    want = stat_values_due.pop_front();
                    if (o_stat_value !== want) begin
                        $error("stat_value: expected %0h, actual %0h", want, o_stat_value);
                        failures++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                w.cmd = i_command;
                w.i_s = i_i_sample;
                w.q_s = i_q_sample;
                w.idx = i_stat_index;
                apply_word(w);
            end
        end
    end

    // run limit
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_level(logic [CFG_BITS-1:0] idx, logic [LEVEL_BITS-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_levels(logic [LEVEL_BITS-1:0] near_val,
                               logic [LEVEL_BITS-1:0] sat_val);
        write_level(CFG_NEAR_LEVEL, near_val);
        write_level(CFG_SAT_LEVEL, sat_val);
        near_level = near_val;
        sat_level  = sat_val;
    endtask

    // wait until every word is in and every read answered, then let records retire
    task automatic settle();
        while (word_queue.size() != 0 || i_in_valid || stat_values_due.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        wipe_stats();
        near_level = NEAR_LEVEL_RST;
        sat_level  = SAT_LEVEL_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bin edges and extremes at the reset levels
        word_queue.push_back(make_word(CMD_RECORD, 0, 0, 0));
        word_queue.push_back(make_word(CMD_RECORD, -32768, 32767, 0));
        word_queue.push_back(make_word(CMD_RECORD, 32767, -32768, 0));
        word_queue.push_back(make_word(CMD_RECORD, 1023, -1024, 0));
        word_queue.push_back(make_word(CMD_RECORD, 1024, -1023, 0));
        word_queue.push_back(make_word(CMD_RECORD, -4095, 4096, 0));
        word_queue.push_back(make_word(CMD_RECORD, 8191, -8192, 0));
        word_queue.push_back(make_word(CMD_RECORD, 16383, -16384, 0));
        word_queue.push_back(make_word(CMD_RECORD, 24575, -24576, 0));
        word_queue.push_back(make_word(CMD_RECORD, 32766, -32767, 0));
        word_queue.push_back(make_word(CMD_RECORD, 29999, -30000, 0));
        // unused command leaves everything alone
        word_queue.push_back(make_word(CMD_UNUSED, -32768, -32768, 31));
        word_queue.push_back(make_word(CMD_READ, 0, 0, 0));
        word_queue.push_back(make_word(CMD_READ, 0, 0, 7));
        word_queue.push_back(make_word(CMD_READ, 0, 0, 15));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_TOTAL));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_SAT));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_NEAR));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_SUMSQ_I));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_SUMSQ_Q));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_PEAK_I));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_PEAK_Q));
        // select past the last statistic reads zero
        word_queue.push_back(make_word(CMD_READ, -1, -1, 23));
        word_queue.push_back(make_word(CMD_READ, -1, -1, 31));
        word_queue.push_back(make_word(CMD_CLEAR, 0, 0, 0));
        word_queue.push_back(make_word(CMD_READ, 0, 0, STAT_PEAK_I));

        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                settle();
                case (p)
                    1: load_levels(16'd0, 16'd0);          // every sample meets both
                    2: load_levels(16'd32768, 16'd32768);  // only full scale
                    3: load_levels(16'hFFFF, 16'hFFFF);    // nothing meets either
                    4: load_levels(16'd1, 16'd16384);
                    default: load_levels(LEVEL_BITS'($urandom_range(0, 32768)),
                                         LEVEL_BITS'($urandom));
                endcase
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                word_queue.push_back(random_word());
        end
        settle();

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
